// ===== src/nntb_pkg.sv =====
// Shared types and constants for the nearest-neighbor tour builder.
// No dependencies; imported by the top level.
`default_nettype none
package nntb_pkg;

  localparam int NODE_FIELD_W = 6;
  localparam int DIST_W       = 32;
  localparam int COST_W       = 38;
  localparam int COUNT_W      = 7;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] NODE_COUNT_MIN   = 7'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_BUILD = 1'b1
  } command_t;

endpackage
`default_nettype wire

// ===== src/nearest_neighbor_tour_builder.sv =====
// Nearest-neighbor tour builder: distance store, visited flags and scan sequencer.
// Depends on nntb_pkg.
// Usage:
//   Input channel (in_valid / in_stall): an item with command write stores
//   distance at (row_node, col_node) and gives no result. An item
//   with command build starts a greedy tour at start_node over node_count nodes.
//   Output channel (out_valid / out_stall): one item per tour node, in order,
//   with tour_position counting from 0; the final item has last set and
//   carries the closed tour cost in tour_cost (zero on all other items).
//   Config channel (cfg_valid / cfg_ready): writes node_count, clamped to
//   2..MAX_NODES at the start of a build; write only while the block is idle.
// Timing: a write item leaves in_stall low. A build item keeps in_stall high until
//   its final item is loaded into the output register: each tour step reads one
//   distance entry per cycle from the single read port of the distance memory and
//   compares it in the shared compare unit (SCAN reads the n entries of the row,
//   then SCAN_END drains, STEP updates and EMIT outputs), and the final step adds
//   RET_WAIT for the return edge read.
// Reset: clears control state and visited flags and sets node_count to 64; the
//   distance memory holds unknown data until written. A stalled receiver holds
//   the output item and the sequencer waits before loading the next one.
`default_nettype none
module nearest_neighbor_tour_builder
  import nntb_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire                     command,
  input  wire  [NODE_FIELD_W-1:0] row_node,
  input  wire  [NODE_FIELD_W-1:0] col_node,
  input  wire  [DIST_W-1:0]       distance,
  input  wire  [NODE_FIELD_W-1:0] start_node,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [NODE_FIELD_W-1:0] tour_node,
  output logic [NODE_FIELD_W-1:0] tour_position,
  output logic                    last,
  output logic [COST_W-1:0]       tour_cost,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [COUNT_W-1:0]      node_count
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = 2 * NODE_W;
  localparam int DEPTH  = 1 << ADDR_W;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    SCAN_END,
    STEP,
    RET_WAIT,
    EMIT
  } state_t;

  state_t              state;
  logic [COUNT_W-1:0]  nodes_cfg;
  logic [CNT_W-1:0]    n_use;
  logic [NODE_W-1:0]   cur;
  logic [NODE_W-1:0]   first;
  logic [NODE_W-1:0]   pos;
  logic [NODE_W-1:0]   idx;
  logic [NODE_W-1:0]   cmp_idx;
  logic                cmp_valid;
  logic                found;
  logic [NODE_W-1:0]   best;
  logic [DIST_W-1:0]   best_d;
  logic [COST_W-1:0]   cost;
  logic [MAX_NODES-1:0] vis;
  logic [NODE_W-1:0]   res_node;
  logic [NODE_W-1:0]   res_pos;
  logic                res_last;
  logic [COST_W-1:0]   res_cost;

  logic [DIST_W-1:0]   mem [DEPTH];
  logic [DIST_W-1:0]   rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                mem_we;
  logic                mem_re;

  logic                in_take;
  logic                out_free;
  logic [COUNT_W-1:0]  nodes_clamped;
  logic [COUNT_W-1:0]  start_sel;
  logic [COST_W-1:0]   cost_step;
  logic                step_last;

  assign in_stall  = (state != IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (nodes_cfg < NODE_COUNT_MIN) begin
      nodes_clamped = NODE_COUNT_MIN;
    end else if (nodes_cfg > COUNT_W'(MAX_NODES)) begin
      nodes_clamped = COUNT_W'(MAX_NODES);
    end else begin
      nodes_clamped = nodes_cfg;
    end
    if (COUNT_W'(start_node) >= nodes_clamped) begin
      start_sel = nodes_clamped - 7'd1;
    end else begin
      start_sel = COUNT_W'(start_node);
    end
  end

  assign cost_step = cost + COST_W'(best_d);
  assign step_last = (CNT_W'(pos) + CNT_W'(1)) == (n_use - CNT_W'(1));

  assign mem_we  = in_take && (command == CMD_WRITE) &&
                   (COUNT_W'(row_node) < COUNT_W'(MAX_NODES)) &&
                   (COUNT_W'(col_node) < COUNT_W'(MAX_NODES));
  assign wr_addr = {row_node[NODE_W-1:0], col_node[NODE_W-1:0]};
  assign mem_re  = (state == SCAN) || (state == STEP);
  assign rd_addr = (state == STEP) ? {best, first} : {cur, idx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= distance;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      nodes_cfg <= NODE_COUNT_RESET;
      n_use     <= CNT_W'(MAX_NODES);
      cur       <= '0;
      first     <= '0;
      pos       <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      cost      <= '0;
      vis       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        nodes_cfg <= node_count;
      end
      if (out_valid && !out_stall && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      cmp_valid <= (state == SCAN);
      cmp_idx   <= idx;
      if (cmp_valid && !vis[cmp_idx] && (!found || rd_data < best_d)) begin
        found  <= 1'b1;
        best   <= cmp_idx;
        best_d <= rd_data;
      end
      case (state)
        IDLE: begin
          if (in_take && command == CMD_BUILD) begin
            n_use    <= CNT_W'(nodes_clamped);
            first    <= NODE_W'(start_sel);
            cur      <= NODE_W'(start_sel);
            vis      <= MAX_NODES'(1) << NODE_W'(start_sel);
            cost     <= '0;
            pos      <= '0;
            res_node <= NODE_W'(start_sel);
            res_pos  <= '0;
            res_last <= 1'b0;
            res_cost <= '0;
            state    <= EMIT;
          end
        end
        SCAN: begin
          idx <= idx + NODE_W'(1);
          if (CNT_W'(idx) == n_use - CNT_W'(1)) begin
            state <= SCAN_END;
          end
        end
        SCAN_END: begin
          state <= STEP;
        end
        STEP: begin
          cost          <= cost_step;
          vis[best]     <= 1'b1;
          cur           <= best;
          pos           <= pos + NODE_W'(1);
          res_node      <= best;
          res_pos       <= pos + NODE_W'(1);
          res_last      <= 1'b0;
          res_cost      <= '0;
          if (step_last) begin
            state <= RET_WAIT;
          end else begin
            state <= EMIT;
          end
        end
        RET_WAIT: begin
          cost     <= cost + COST_W'(rd_data);
          res_cost <= cost + COST_W'(rd_data);
          res_last <= 1'b1;
          state    <= EMIT;
        end
        EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            tour_node     <= NODE_FIELD_W'(res_node);
            tour_position <= NODE_FIELD_W'(res_pos);
            last          <= res_last;
            tour_cost     <= res_cost;
            idx           <= '0;
            found         <= 1'b0;
            if (res_last) begin
              state <= IDLE;
            end else begin
              state <= SCAN;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
